// File: rtl/dts_pkg.sv
// dts_pkg: widths, calendar constants and lookup functions for the
// date-to-seconds converter. No dependencies; used by all rtl files.

package dts_pkg;

  // field widths of one date item and one result item
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned TOTAL_W  = 33;

  // calendar range
  localparam int unsigned END_YEAR   = 2170;
  localparam int unsigned FIRST_YEAR = 2001;
  localparam int unsigned BASE_YEAR  = 2000;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MAX_HOUR      = 24;
  localparam int unsigned MAX_MINUTE    = 60;
  localparam int unsigned MAX_SECOND    = 60;
  localparam int unsigned MAX_MONTH     = 12;
  localparam int unsigned FEB           = 2;

  // elapsed whole years since the base year, at most END_YEAR - BASE_YEAR
  localparam int unsigned YY_W = $clog2(END_YEAR - BASE_YEAR + 1);
  // elapsed whole days, including the current partial year
  localparam int unsigned DAYS_MAX = (END_YEAR - BASE_YEAR + 1) * 366 + 31;
  localparam int unsigned DAYS_W   = $clog2(DAYS_MAX + 1);
  // seconds within a day, up to 24:60:60
  localparam int unsigned TOD_MAX = MAX_HOUR * SECS_PER_HOUR + MAX_MINUTE * SECS_PER_MIN
                                    + MAX_SECOND;
  localparam int unsigned TOD_W   = $clog2(TOD_MAX + 1);
  localparam int unsigned SPD_W   = $clog2(SECS_PER_DAY + 1);
  localparam int unsigned PROD_W  = DAYS_W + SPD_W + 1;

  // days-of-year width, used by days_before
  localparam int unsigned DOY_W = 9;

  // non-leap century years; only CENT_A is inside the supported range
  localparam int unsigned CENT_A = 2100;
  localparam int unsigned CENT_B = 2200;
  localparam int unsigned CENT_C = 2300;

  // reciprocal of 100 as 41 / 4096, exact for values below 512
  localparam int unsigned RECIP100_MUL = 41;
  localparam int unsigned RECIP100_SH  = 12;
  localparam int unsigned QUAD_CENT    = 400;

  // working values carried from the first to the second stage
  typedef struct packed {
    logic              date_ok;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } dts_mid_t;

  // days before the start of a month index in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // month length in the given year, zero for month zero and beyond december
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:    n = leap ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // gregorian leap test, exact for every year of the accepted range
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_W'(CENT_A)) && (y != YEAR_W'(CENT_B))
           && (y != YEAR_W'(CENT_C));
  endfunction

  // v / 100 by reciprocal multiply
  function automatic logic [YY_W-1:0] div100(input logic [YY_W-1:0] v);
    logic [YY_W+6:0] p;
    p = (YY_W+7)'(v) * (YY_W+7)'(RECIP100_MUL);
    return YY_W'(p >> RECIP100_SH);
  endfunction

  // v / 400, which is zero or one below 512
  function automatic logic [YY_W-1:0] div400(input logic [YY_W-1:0] v);
    return YY_W'(32'(v) >= 32'(QUAD_CENT));
  endfunction

endpackage

// File: rtl/dts_if.sv
// dts_item_if, dts_result_if: valid/ready channels for date items and
// second counts. Depends on dts_pkg for field widths.

interface dts_item_if;
  logic                             valid;
  logic                             ready;
  logic [dts_pkg::YEAR_W-1:0]       year;
  logic [dts_pkg::MONTH_W-1:0]      month;
  logic [dts_pkg::DAY_W-1:0]        day;
  logic [dts_pkg::HOUR_W-1:0]       hour;
  logic [dts_pkg::MINUTE_W-1:0]     minute;
  logic [dts_pkg::SECOND_W-1:0]     second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface dts_result_if;
  logic                         valid;
  logic                         ready;
  logic [dts_pkg::TOTAL_W-1:0]  total_seconds;
  logic                         date_valid;

  modport source (output valid, total_seconds, date_valid, input ready);
  modport sink   (input valid, total_seconds, date_valid, output ready);
endinterface

// File: rtl/date_to_seconds_since_2000.sv
// date_to_seconds_since_2000: top level of the date-to-seconds converter.
// Depends on dts_pkg and the channel interfaces in dts_if.sv.
//
// Usage
//   item   : sink channel, one date (year, month, day, hour, minute, second)
//            per transfer.
//   result : source channel, one result per date: total_seconds counted from
//            the start of 2001 and date_valid; an invalid date gives zero
//            with date_valid low.
//   Path: each item passes through the stages in order (input
//   register, day/time-of-day stage, output register holding the
//   day-to-seconds product); result.valid rises when it reaches the
//   output register.
//   Throughput: one date per cycle unless stalled; each stage holds one item
//   and moves on whenever the stage after it is empty or moving.
//   Stall: when result.ready is low the output register holds its item and
//   the stages before it keep filling; item.ready drops once all three hold
//   an item. Up to three items may be in flight.
//   Reset: rst (synchronous) empties all stages; no result is shown until a
//   new item is taken.

module date_to_seconds_since_2000 (
  input  logic                clk,
  input  logic                rst,
  dts_item_if.sink            item,
  dts_result_if.source        result
);

  // stage 1: input register
  logic                                s1_valid;
  logic [dts_pkg::YEAR_W-1:0]          s1_year;
  logic [dts_pkg::MONTH_W-1:0]         s1_month;
  logic [dts_pkg::DAY_W-1:0]           s1_day;
  logic [dts_pkg::HOUR_W-1:0]          s1_hour;
  logic [dts_pkg::MINUTE_W-1:0]        s1_minute;
  logic [dts_pkg::SECOND_W-1:0]        s1_second;

  // stage 2: elapsed days and time of day
  logic                                s2_valid;
  dts_pkg::dts_mid_t                   s2;
  dts_pkg::dts_mid_t                   s2_next;

  // stage 3: output register
  logic                                s3_valid;
  logic [dts_pkg::TOTAL_W-1:0]         s3_total;
  logic                                s3_ok;
  logic [dts_pkg::TOTAL_W-1:0]         s3_total_next;

  logic adv1, adv2, adv3;

  // stage advance chain
  assign adv3 = !s3_valid || result.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign item.ready = adv1;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= item.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_year   <= item.year;
      s1_month  <= item.month;
      s1_day    <= item.day;
      s1_hour   <= item.hour;
      s1_minute <= item.minute;
      s1_second <= item.second;
    end
  end

  // validation, elapsed days and seconds within the day
  logic                          leap;
  logic                          ok;
  logic [dts_pkg::YY_W-1:0]      yy;
  logic [dts_pkg::DAYS_W-1:0]    days_y;
  logic [dts_pkg::MONTH_W-1:0]   mc;
  logic                          leap_add;

  always_comb begin
    leap = dts_pkg::is_leap(s1_year);

    ok = 1'b1;
    if (s1_year < dts_pkg::YEAR_W'(dts_pkg::FIRST_YEAR) ||
        s1_year > dts_pkg::YEAR_W'(dts_pkg::END_YEAR)) ok = 1'b0;
    if (s1_month > dts_pkg::MONTH_W'(dts_pkg::MAX_MONTH)) ok = 1'b0;
    if (s1_day > dts_pkg::month_len(s1_month, leap)) ok = 1'b0;
    if (s1_hour > dts_pkg::HOUR_W'(dts_pkg::MAX_HOUR) ||
        s1_minute > dts_pkg::MINUTE_W'(dts_pkg::MAX_MINUTE) ||
        s1_second > dts_pkg::SECOND_W'(dts_pkg::MAX_SECOND)) ok = 1'b0;
    if (s1_day == '0 && (s1_hour != '0 || s1_minute != '0 || s1_second != '0)) ok = 1'b0;
    if (s1_hour == '0 && (s1_minute != '0 || s1_second != '0)) ok = 1'b0;
    if (s1_minute == '0 && s1_second != '0) ok = 1'b0;

    // the named year counts in full only when the month is zero
    if (s1_month != '0) begin
      yy = dts_pkg::YY_W'(s1_year - dts_pkg::YEAR_W'(dts_pkg::FIRST_YEAR));
    end else begin
      yy = dts_pkg::YY_W'(s1_year - dts_pkg::YEAR_W'(dts_pkg::BASE_YEAR));
    end

    days_y = dts_pkg::DAYS_W'(yy) * dts_pkg::DAYS_W'(dts_pkg::DAYS_PER_YEAR)
           + dts_pkg::DAYS_W'(yy >> 2)
           - dts_pkg::DAYS_W'(dts_pkg::div100(yy))
           + dts_pkg::DAYS_W'(dts_pkg::div400(yy));

    // whole months elapsed in the current year
    if (s1_day == '0 || s1_month == '0) begin
      mc = s1_month;
    end else begin
      mc = s1_month - dts_pkg::MONTH_W'(1);
    end
    leap_add = leap && (mc >= dts_pkg::MONTH_W'(dts_pkg::FEB));

    s2_next.date_ok = ok;
    s2_next.days = days_y + dts_pkg::DAYS_W'(dts_pkg::days_before(mc))
                 + dts_pkg::DAYS_W'(leap_add) + dts_pkg::DAYS_W'(s1_day);
    s2_next.tod  = dts_pkg::TOD_W'(s1_hour) * dts_pkg::TOD_W'(dts_pkg::SECS_PER_HOUR)
                 + dts_pkg::TOD_W'(s1_minute) * dts_pkg::TOD_W'(dts_pkg::SECS_PER_MIN)
                 + dts_pkg::TOD_W'(s1_second);
  end

  always_ff @(posedge clk) begin
    if (adv2) s2 <= s2_next;
  end

  // days to seconds, forced to zero for an invalid date
  logic [dts_pkg::PROD_W-1:0] prod;

  always_comb begin
    prod = dts_pkg::PROD_W'(s2.days) * dts_pkg::PROD_W'(dts_pkg::SECS_PER_DAY)
         + dts_pkg::PROD_W'(s2.tod);
    s3_total_next = s2.date_ok ? dts_pkg::TOTAL_W'(prod) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_total <= s3_total_next;
      s3_ok    <= s2.date_ok;
    end
  end

  // result channel
  assign result.valid         = s3_valid;
  assign result.total_seconds = s3_total;
  assign result.date_valid    = s3_ok;

endmodule

// File: rtl/dts_checker.sv
// dts_port_checker: port-level assertions for date_to_seconds_since_2000, and
// the bind that attaches them. Depends on dts_pkg and the top level.

module dts_port_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [dts_pkg::TOTAL_W-1:0]  total_seconds,
  input logic                         date_valid
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(total_seconds) && $stable(date_valid))
    else $error("stalled result changed");

  // an invalid date always reports zero seconds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !date_valid |-> total_seconds == '0)
    else $error("invalid date with nonzero count");

  // a ready receiver never blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    result_ready |-> item_ready)
    else $error("input stalled while output ready");

  // an accepted item yields a valid result while the receiver stays ready
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready ##1 result_ready ##1 result_ready |=> result_valid)
    else $error("result missing after three cycles");

endmodule

bind date_to_seconds_since_2000 dts_port_checker u_dts_port_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .total_seconds (result.total_seconds),
  .date_valid    (result.date_valid)
);
